// ----- src/cbs_pkg.sv -----
`default_nettype none

package cbs_pkg;

    // Field widths of the request and result channels.
    localparam int OP_W    = 3;
    localparam int ENTRY_W = 16;
    localparam int FIDX_W  = 8;
    localparam int COUNT_W = 9;

    // Widest bit position inside a cell (cells are at most 64 bits wide).
    localparam int POS_W = 6;

    // Default geometry.
    localparam int NBITS_DEF      = 256;
    localparam int CELL_WIDTH_DEF = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 3'd0,
        OP_ADD        = 3'd1,
        OP_DELETE     = 3'd2,
        OP_TEST       = 3'd3,
        OP_COMPLEMENT = 3'd4,
        OP_RESTART    = 3'd5,
        OP_NEXT       = 3'd6
    } t_op;

    // Lowest qualifying set bit of one cell.
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_find;

endpackage

`default_nettype wire

// ----- src/cbs_cell_ram.sv -----
`default_nettype none

module cbs_cell_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- src/cbs_index_split.sv -----
`default_nettype none

// Splits an element index into cell number and bit offset in two stages:
// a reciprocal multiply gives a quotient that is exact or one short, and
// the second stage fixes it with one compare and subtract.
module cbs_index_split
    import cbs_pkg::*;
#(
    parameter int CELL_WIDTH = CELL_WIDTH_DEF,
    parameter int CIDX_W     = 5,
    parameter int OFF_W      = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [ENTRY_W-1:0] i_entry,
    output logic                    o_done,
    output logic      [CIDX_W-1:0]  o_cell,
    output logic      [OFF_W-1:0]   o_off
);

    localparam int RECIP_W = ENTRY_W + 1;
    localparam int PROD_W  = ENTRY_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << ENTRY_W) / CELL_WIDTH);
    localparam logic [ENTRY_W-1:0] CW    = ENTRY_W'(CELL_WIDTH);

    logic               r_v1, r_v2;
    logic [ENTRY_W-1:0] r_entry;
    logic [ENTRY_W-1:0] r_q0;
    logic [CIDX_W-1:0]  r_cell;
    logic [OFF_W-1:0]   r_off;

    logic [PROD_W-1:0]  prod;
    logic [ENTRY_W-1:0] rem0;
    logic [ENTRY_W-1:0] q_fix;
    logic [ENTRY_W-1:0] rem_fix;

    assign prod = PROD_W'(i_entry) * PROD_W'(RECIP);

    always_comb begin
        rem0 = r_entry - ENTRY_W'(r_q0 * CW);
        if (rem0 >= CW) begin
            q_fix   = r_q0 + 1'b1;
            rem_fix = rem0 - CW;
        end else begin
            q_fix   = r_q0;
            rem_fix = rem0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        r_entry <= i_entry;
        r_q0    <= prod[ENTRY_W +: ENTRY_W];
        r_cell  <= q_fix[CIDX_W-1:0];
        r_off   <= rem_fix[OFF_W-1:0];
    end

    assign o_done = r_v2;
    assign o_cell = r_cell;
    assign o_off  = r_off;

endmodule

`default_nettype wire

// ----- src/cbs_first_set.sv -----
`default_nettype none

// Finds the lowest set bit of a cell at or above a starting offset.
module cbs_first_set
    import cbs_pkg::*;
#(
    parameter int CELL_WIDTH = CELL_WIDTH_DEF,
    parameter int OFF_W      = 3
) (
    input  wire logic [CELL_WIDTH-1:0] i_word,
    input  wire logic [OFF_W-1:0]      i_off,
    output t_find                      o_find
);

    always_comb begin
        o_find = '0;
        for (int i = CELL_WIDTH - 1; i >= 0; i--) begin
            if (i_word[i] && (OFF_W'(i) >= i_off)) begin
                o_find.hit = 1'b1;
                o_find.pos = POS_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/complementable_bitmap_set_top.sv -----
// Request paths: complement, restart, the unused code and an out-of-range entry go straight to
// the result; add, delete and test pass index split, cell read and, where the bit changes, write
// back; next member reads cells one a cycle until it finds a member or the end; clear runs the
// clearing pass first. Flow: one request in flight; the next is taken once the previous result
// is registered, later while an earlier result still waits for ready. Reset (synchronous, active
// low) empties the set, then a clearing pass zeroes one cell a cycle, taking no requests.
`default_nettype none

module complementable_bitmap_set_top
    import cbs_pkg::*;
#(
    parameter int NBITS      = NBITS_DEF,
    parameter int CELL_WIDTH = CELL_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [ENTRY_W-1:0] i_entry,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_is_member,
    output logic                    o_found,
    output logic      [FIDX_W-1:0]  o_found_index,
    output logic      [COUNT_W-1:0] o_count,
    output logic                    o_is_empty,
    output logic                    o_out_of_range
);

    // Geometry derived from the parameters. The cursor is kept as a cell
    // number, a bit offset inside that cell and the index of the cell's bit 0.
    localparam int NCELLS    = (NBITS + CELL_WIDTH - 1) / CELL_WIDTH;
    localparam int CIDX_W    = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int CCNT_W    = $clog2(NCELLS + 1);
    localparam int OFF_W     = $clog2(CELL_WIDTH);
    localparam int CNT_W     = $clog2(NBITS + 1);
    localparam int BASE_W    = $clog2(NCELLS * CELL_WIDTH + 1);
    localparam int LAST_BITS = NBITS - (NCELLS - 1) * CELL_WIDTH;
    localparam logic [CELL_WIDTH-1:0] LAST_MASK =
        {CELL_WIDTH{1'b1}} >> (CELL_WIDTH - LAST_BITS);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_SPLIT,
        S_RMW,
        S_SCAN,
        S_RESP
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic                r_inv;
    logic [CNT_W-1:0]    r_count;
    logic [CCNT_W-1:0]   r_cur_cell;
    logic [OFF_W-1:0]    r_cur_off;
    logic [BASE_W-1:0]   r_base;
    logic [CIDX_W-1:0]   r_sweep;
    logic                r_sweep_resp;
    logic [CIDX_W-1:0]   r_acc_cell;
    logic [OFF_W-1:0]    r_acc_off;
    logic                r_res_mem;
    logic                r_res_found;
    logic [FIDX_W-1:0]   r_res_fidx;
    logic                r_res_oor;
    logic                r_out_valid;
    logic                r_out_mem;
    logic                r_out_found;
    logic [FIDX_W-1:0]   r_out_fidx;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_empty;
    logic                r_out_oor;

    logic                  in_fire;
    logic                  out_free;
    logic                  split_done;
    logic [CIDX_W-1:0]     split_cell;
    logic [OFF_W-1:0]      split_off;
    logic                  ram_wr_en;
    logic [CIDX_W-1:0]     ram_wr_addr;
    logic [CELL_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [CIDX_W-1:0]     ram_rd_addr;
    logic [CELL_WIDTH-1:0] ram_rd_data;
    logic                  member;
    logic [CELL_WIDTH-1:0] scan_word;
    t_find                 find;
    logic [CCNT_W-1:0]     next_cell;
    logic                  cursor_done;
    logic                  in_range;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign in_range    = ({1'b0, i_entry} < (ENTRY_W + 1)'(NBITS));
    assign cursor_done = (r_cur_cell == CCNT_W'(NCELLS));
    assign next_cell   = r_cur_cell + 1'b1;

    // The cell under a read-modify-write; membership is the stored bit
    // differing from the complement flag.
    assign member = ram_rd_data[r_acc_off] ^ r_inv;

    // Under complement, bits past the end of the last cell read as members,
    // so they are masked off before the search.
    assign scan_word = (ram_rd_data ^ {CELL_WIDTH{r_inv}})
                     & ((r_cur_cell == CCNT_W'(NCELLS - 1)) ? LAST_MASK : {CELL_WIDTH{1'b1}});

    cbs_index_split #(
        .CELL_WIDTH (CELL_WIDTH),
        .CIDX_W     (CIDX_W),
        .OFF_W      (OFF_W)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_entry (i_entry),
        .o_done  (split_done),
        .o_cell  (split_cell),
        .o_off   (split_off)
    );

    cbs_first_set #(
        .CELL_WIDTH (CELL_WIDTH),
        .OFF_W      (OFF_W)
    ) u_find (
        .i_word (scan_word),
        .i_off  (r_cur_off),
        .o_find (find)
    );

    cbs_cell_ram #(
        .DEPTH  (NCELLS),
        .WIDTH  (CELL_WIDTH),
        .ADDR_W (CIDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Memory port control. Only one request is in flight, so a write back
    // always completes before the next read of any cell is issued.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_acc_cell;
        ram_wr_data = ram_rd_data ^ (CELL_WIDTH'(1) << r_acc_off);
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_cur_cell[CIDX_W-1:0];
        unique case (r_state)
            S_SWEEP: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_sweep;
                ram_wr_data = '0;
            end
            S_IDLE: begin
                ram_rd_en = in_fire && (t_op'(i_op) == OP_NEXT) && !cursor_done;
            end
            S_SPLIT: begin
                ram_rd_en   = split_done;
                ram_rd_addr = split_cell;
            end
            S_RMW: begin
                ram_wr_en = ((r_op == OP_ADD) && !member) || ((r_op == OP_DELETE) && member);
            end
            S_SCAN: begin
                ram_rd_en   = !find.hit && (next_cell != CCNT_W'(NCELLS));
                ram_rd_addr = next_cell[CIDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep      <= '0;
            r_sweep_resp <= 1'b0;
            r_inv        <= 1'b0;
            r_count      <= '0;
            r_cur_cell   <= '0;
            r_cur_off    <= '0;
            r_base       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // In S_RESP a taken result is replaced by the next one below.
            if (r_out_valid && i_out_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == CIDX_W'(NCELLS - 1)) begin
                        r_state <= r_sweep_resp ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_op        <= t_op'(i_op);
                        r_res_mem   <= 1'b0;
                        r_res_found <= 1'b0;
                        r_res_fidx  <= '0;
                        r_res_oor   <= 1'b0;
                        r_state     <= S_RESP;
                        case (t_op'(i_op))
                            OP_CLEAR: begin
                                r_inv        <= 1'b0;
                                r_count      <= '0;
                                r_cur_cell   <= '0;
                                r_cur_off    <= '0;
                                r_base       <= '0;
                                r_sweep      <= '0;
                                r_sweep_resp <= 1'b1;
                                r_state      <= S_SWEEP;
                            end
                            OP_ADD, OP_DELETE, OP_TEST: begin
                                if (in_range) begin
                                    r_state <= S_SPLIT;
                                end else begin
                                    r_res_oor <= 1'b1;
                                end
                            end
                            OP_COMPLEMENT: begin
                                r_inv   <= !r_inv;
                                r_count <= CNT_W'(NBITS) - r_count;
                            end
                            OP_RESTART: begin
                                r_cur_cell <= '0;
                                r_cur_off  <= '0;
                                r_base     <= '0;
                            end
                            OP_NEXT: begin
                                if (!cursor_done) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SPLIT: begin
                    if (split_done) begin
                        r_acc_cell <= split_cell;
                        r_acc_off  <= split_off;
                        r_state    <= S_RMW;
                    end
                end
                S_RMW: begin
                    r_res_mem <= (r_op == OP_ADD || r_op == OP_TEST) && member;
                    if ((r_op == OP_ADD) && !member) begin
                        r_count <= r_count + 1'b1;
                    end
                    if ((r_op == OP_DELETE) && member) begin
                        r_count <= r_count - 1'b1;
                    end
                    r_state <= S_RESP;
                end
                S_SCAN: begin
                    if (find.hit) begin
                        r_res_found <= 1'b1;
                        r_res_fidx  <= FIDX_W'(r_base + BASE_W'(find.pos));
                        r_state     <= S_RESP;
                        if (find.pos == POS_W'(CELL_WIDTH - 1)) begin
                            r_cur_cell <= next_cell;
                            r_cur_off  <= '0;
                            r_base     <= r_base + BASE_W'(CELL_WIDTH);
                        end else begin
                            r_cur_off <= OFF_W'(find.pos) + 1'b1;
                        end
                    end else begin
                        r_cur_cell <= next_cell;
                        r_cur_off  <= '0;
                        r_base     <= r_base + BASE_W'(CELL_WIDTH);
                        if (next_cell == CCNT_W'(NCELLS)) begin
                            r_state <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_mem   <= r_res_mem;
                        r_out_found <= r_res_found;
                        r_out_fidx  <= r_res_fidx;
                        r_out_count <= COUNT_W'(r_count);
                        r_out_empty <= (r_count == '0);
                        r_out_oor   <= r_res_oor;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_member    = r_out_mem;
    assign o_found        = r_out_found;
    assign o_found_index  = r_out_fidx;
    assign o_count        = r_out_count;
    assign o_is_empty     = r_out_empty;
    assign o_out_of_range = r_out_oor;

endmodule

`default_nettype wire

// ----- src/cbs_checker.sv -----
`default_nettype none

module cbs_checker
    import cbs_pkg::*;
#(
    parameter int NBITS = NBITS_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic [OP_W-1:0]    i_op,
    input wire logic [ENTRY_W-1:0] i_entry,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic               o_is_member,
    input wire logic               o_found,
    input wire logic [FIDX_W-1:0]  o_found_index,
    input wire logic [COUNT_W-1:0] o_count,
    input wire logic               o_is_empty,
    input wire logic               o_out_of_range
);

    // A waiting request holds.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable({i_op, i_entry}))
        else $error("request changed while waiting");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable({o_is_member, o_found, o_found_index, o_count,
                        o_is_empty, o_out_of_range}))
        else $error("result changed while stalled");

    // The empty flag agrees with the count while the count fits its field.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (NBITS >= 512) || (o_is_empty == (o_count == '0)))
        else $error("empty flag disagrees with count");

    // A found member means the set is not empty and no other flag is set.
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> !o_is_empty && !o_is_member && !o_out_of_range)
        else $error("found result carries inconsistent flags");

    // An ignored out-of-range request reports nothing else.
    a_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> !o_is_member && !o_found && (o_found_index == '0))
        else $error("out-of-range result carries other flags");

endmodule

bind complementable_bitmap_set_top cbs_checker #(.NBITS(NBITS)) u_cbs_checker (.*);

`default_nettype wire
